@@ hdl/zcg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zcg_pkg: shared types and constants
// Field widths, reset gain, sign reference codes and the scaler result bundle
// for the zero-crossing gain block.
// ----------------------------------------------------------------------------
package zcg_pkg;

    // Fixed field widths
    localparam int CHAN_IN_BITS = 3;
    localparam int GAIN_BITS    = 18;
    localparam int OUT_BITS     = 24;
    localparam int FRAC_BITS    = 16;

    // Gain after reset, 0.81 in Q2.16
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 18'd53084;

    // Sign reference held per channel
    typedef enum logic [1:0] {
        SREF_UNSET = 2'd0,
        SREF_POS   = 2'd1,
        SREF_NEG   = 2'd2
    } sref_t;

    // Scaled sample and its magnitude
    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic        [OUT_BITS-1:0] mag;
    } scale_res_t;

endpackage
`default_nettype wire

@@ hdl/zcg_scale.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zcg_scale: sample scaler
// Multiplies a signed sample by an unsigned Q2.16 gain, rounds half up,
// saturates to the output width and forms the absolute value.
// ----------------------------------------------------------------------------
module zcg_scale
    import zcg_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire logic        [GAIN_BITS-1:0]   gain,
    output scale_res_t                         res
);

    localparam int PW = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int QW = PW - FRAC_BITS;
    localparam int EW = (QW > OUT_BITS) ? QW : OUT_BITS;
    localparam logic signed [PW-1:0] ROUND_BIAS = PW'(1 << (FRAC_BITS - 1));
    localparam logic signed [EW-1:0] SAT_HI = EW'((1 << (OUT_BITS - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       rnd;
    logic signed [QW-1:0]       quo;
    logic signed [EW-1:0]       quo_ext;
    logic signed [OUT_BITS-1:0] sat;

    // Multiply and round half up
    always_comb begin
        prod    = PW'($signed(sample)) * PW'($signed({1'b0, gain}));
        rnd     = prod + ROUND_BIAS;
        quo     = rnd[PW-1:FRAC_BITS];
        quo_ext = EW'(quo);
    end

    // Saturate and take the magnitude
    always_comb begin
        if (quo_ext > SAT_HI) begin
            sat = SAT_HI[OUT_BITS-1:0];
        end else if (quo_ext < SAT_LO) begin
            sat = SAT_LO[OUT_BITS-1:0];
        end else begin
            sat = quo_ext[OUT_BITS-1:0];
        end
        res.value = sat;
        res.mag   = sat[OUT_BITS-1] ? (~sat + OUT_BITS'(1)) : sat;
    end

endmodule
`default_nettype wire

@@ hdl/zero_cross_gain_with_peak_meter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zero_cross_gain_with_peak_meter: per-channel gain switch at zero crossings
// Applies a per-channel gain that changes only at a zero crossing of the
// signal, saturates the scaled sample and keeps a per-channel peak hold.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Beat contents
//  s_        in         s_valid/s_ready    channel, sample_in, target_gain,
//                                          read_peak
//  m_        out        m_valid/m_ready    sample_out, gain_used,
//                                          gain_switched, peak_level
//
// One beat per cycle sustained while the result is not stalled; each beat
// passes an input register, then one pass of multiply, round, saturate and
// peak compare into the result register, where the channel state is also
// updated. Reset (aresetn low, synchronous) restores every channel's gain
// to 0.81, clears its sign reference and peak hold at once. A stalled
// result holds both stages; the input register takes a beat while the
// result register waits only if the input register is empty.
// ----------------------------------------------------------------------------
module zero_cross_gain_with_peak_meter
    import zcg_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [CHAN_IN_BITS-1:0]       s_channel,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire logic [GAIN_BITS-1:0]          s_target_gain,
    input  wire logic                          s_read_peak,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [OUT_BITS-1:0]         m_sample_out,
    output logic [GAIN_BITS-1:0]               m_gain_used,
    output logic                               m_gain_switched,
    output logic [OUT_BITS-1:0]                m_peak_level
);

    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_MAP = 1 << CHAN_IN_BITS;

    typedef logic [CW-1:0] wrap_tab_t [CHAN_MAP];

    function automatic wrap_tab_t build_wrap();
        wrap_tab_t t;
        for (int i = 0; i < CHAN_MAP; i++) begin
            t[i] = CW'(i % CHANNELS);
        end
        return t;
    endfunction

    // Channel index folded into the channel count
    localparam wrap_tab_t WRAP_TAB = build_wrap();

    // Input stage
    logic                          in_valid_reg;
    logic [CHAN_IN_BITS-1:0]       chan_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic [GAIN_BITS-1:0]          tgt_reg;
    logic                          rd_reg;

    // Result stage
    logic                          out_valid_reg;
    logic signed [OUT_BITS-1:0]    sample_out_reg;
    logic [GAIN_BITS-1:0]          gain_used_reg;
    logic                          switched_reg;
    logic [OUT_BITS-1:0]           peak_level_reg;

    // Per-channel state
    logic [GAIN_BITS-1:0]          gain_reg [CHANNELS];
    sref_t                         sref_reg [CHANNELS];
    logic [OUT_BITS-1:0]           peak_reg [CHANNELS];

    logic                          advance;
    logic [CW-1:0]                 idx;
    logic [GAIN_BITS-1:0]          cur_gain;
    sref_t                         cur_sref;
    logic [OUT_BITS-1:0]           cur_peak;
    logic                          pending;
    logic                          is_zero;
    sref_t                         samp_sign;
    sref_t                         ref_eff;
    logic                          do_switch;
    logic [GAIN_BITS-1:0]          gain_next;
    sref_t                         sref_next;
    logic [OUT_BITS-1:0]           peak_new;
    logic [OUT_BITS-1:0]           peak_next;
    scale_res_t                    scaled;

    // Move the input stage on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Capture input beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            chan_reg <= s_channel;
            samp_reg <= s_sample_in;
            tgt_reg  <= s_target_gain;
            rd_reg   <= s_read_peak;
        end
    end

    // Look up the channel and decide on a gain switch
    always_comb begin
        idx       = WRAP_TAB[chan_reg];
        cur_gain  = gain_reg[idx];
        cur_sref  = sref_reg[idx];
        cur_peak  = peak_reg[idx];
        pending   = (tgt_reg != cur_gain);
        is_zero   = (samp_reg == '0);
        samp_sign = (!samp_reg[SAMPLE_BITS-1] && !is_zero) ? SREF_POS : SREF_NEG;
        ref_eff   = (cur_sref == SREF_UNSET) ? samp_sign : cur_sref;
        do_switch = pending && ((samp_sign != ref_eff) || is_zero);
        gain_next = do_switch ? tgt_reg : cur_gain;
        if (!pending) begin
            sref_next = cur_sref;
        end else if (do_switch) begin
            sref_next = SREF_UNSET;
        end else begin
            sref_next = samp_sign;
        end
    end

    zcg_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .sample (samp_reg),
        .gain   (gain_next),
        .res    (scaled)
    );

    // Update the peak hold, clear it on a read
    always_comb begin
        peak_new  = (scaled.mag > cur_peak) ? scaled.mag : cur_peak;
        peak_next = rd_reg ? '0 : peak_new;
    end

    // Write back channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                gain_reg[c] <= GAIN_RESET;
                sref_reg[c] <= SREF_UNSET;
                peak_reg[c] <= '0;
            end
        end else if (advance) begin
            gain_reg[idx] <= gain_next;
            sref_reg[idx] <= sref_next;
            peak_reg[idx] <= peak_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            sample_out_reg <= scaled.value;
            gain_used_reg  <= gain_next;
            switched_reg   <= do_switch;
            peak_level_reg <= peak_new;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_sample_out    = sample_out_reg;
    assign m_gain_used     = gain_used_reg;
    assign m_gain_switched = switched_reg;
    assign m_peak_level    = peak_level_reg;

endmodule
`default_nettype wire

@@ hdl/zcg_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// zcg_checker: port-level checks
// Watches the result channel and reset behaviour of the top level.
// ----------------------------------------------------------------------------
module zcg_checker
    import zcg_pkg::*;
(
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic signed [OUT_BITS-1:0]  m_sample_out,
    input wire logic [GAIN_BITS-1:0]        m_gain_used,
    input wire logic                        m_gain_switched,
    input wire logic [OUT_BITS-1:0]         m_peak_level
);

    logic [OUT_BITS-1:0] out_mag;

    assign out_mag = m_sample_out[OUT_BITS-1] ? (~m_sample_out + OUT_BITS'(1))
                                              : m_sample_out;

    // No result beat straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input side free straight after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
            && $stable(m_gain_used) && $stable(m_gain_switched)
            && $stable(m_peak_level))
        else $error("stalled result changed");

    // Reported peak covers this beat's own magnitude
    a_peak_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_level >= out_mag)
        else $error("peak below sample magnitude");

endmodule

bind zero_cross_gain_with_peak_meter zcg_checker u_zcg_checker (.*);
`default_nettype wire
